### rtl/core/sdof_pkg.sv
`default_nettype none
package sdof_pkg;

  localparam int SampleW  = 32;
  localparam int DataW    = 48;
  localparam int CoefW    = 32;
  localparam int WarmW    = 24;
  localparam int StepW    = 8;
  localparam int WideW    = 80;
  localparam int SumW     = 51;
  localparam int UaccW    = 58;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int DivW     = DataW + 1;
  localparam int DivCntW  = $clog2(DivW + 1);

  // 0.001 in Q0.24
  localparam logic signed [CoefW-1:0] MeanWeight = 32'sd16777;

  localparam logic signed [WideW-1:0] Max48 = 80'sd140737488355327;
  localparam logic signed [WideW-1:0] Min48 = -80'sd140737488355328;

  // configuration register indexes
  localparam logic [2:0] CFG_GAIN   = 3'd0;
  localparam logic [2:0] CFG_MODE   = 3'd1;
  localparam logic [2:0] CFG_WARMUP = 3'd2;
  localparam logic [2:0] CFG_A01    = 3'd3;
  localparam logic [2:0] CFG_A23    = 3'd4;
  localparam logic [2:0] CFG_B01    = 3'd5;
  localparam logic [2:0] CFG_B23    = 3'd6;
  localparam logic [2:0] CFG_OSC    = 3'd7;

  localparam logic [1:0] SEL_DISP = 2'd0;
  localparam logic [1:0] SEL_VEL  = 2'd1;
  localparam logic [1:0] SEL_ACC  = 2'd2;

  typedef enum logic [1:0] {MK_SH8, MK_SH16, MK_SH24, MK_RND24} mul_kind_t;

  typedef enum logic [3:0] {
    OP_GAIN, OP_MEAN,
    OP_A0, OP_A1, OP_B0, OP_B1,
    OP_A2, OP_A3, OP_B2, OP_B3,
    OP_C, OP_W2
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE, B_MUL_ISSUE, B_MUL_WAIT, B_DEMEAN,
    B_DIV_ISSUE, B_DIV_WAIT, B_STEP_END, B_FINISH
  } back_state_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      restart;
    logic                      last;
    logic                      emit;
  } item_t;

  typedef struct packed {
    logic signed [CoefW-1:0] gain;
    logic [9:0]              mode;
    logic [WarmW-1:0]        warmup;
    logic [63:0]             a01;
    logic [63:0]             a23;
    logic [63:0]             b01;
    logic [63:0]             b23;
    logic [63:0]             osc;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    mul_kind_t               kind;
    logic signed [CoefW-1:0] a;
    logic signed [DataW-1:0] x;
  } mul_req_t;

  function automatic logic signed [DataW-1:0] sat48(input logic signed [WideW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > Max48) r = Max48[DataW-1:0];
    else if (v < Min48) r = Min48[DataW-1:0];
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/sdof_queue.sv
`default_nettype none
module sdof_queue import sdof_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  item_t      push_item,
  input  wire logic  pop,
  output item_t      pop_item,
  output logic       full,
  output logic       empty
);

  item_t            entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;

  assign full     = (count == (QPtrW+1)'(QDepth));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  // store beats in arrival order
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sdof_front.sv
`default_nettype none
module sdof_front import sdof_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic signed [SampleW-1:0] sample,
  input  wire logic                      restart,
  input  wire logic                      last,
  input  wire logic [WarmW-1:0]          warmup,
  input  wire logic                      q_full,
  output logic                           push,
  output item_t                          push_item
);

  logic [WarmW-1:0] warm_count;
  logic [WarmW-1:0] warm_base;
  logic             warming;

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  // a restart beat counts as the first warm-up sample
  assign warm_base = restart ? '0 : warm_count;
  assign warming   = (warm_base < warmup);

  assign push_item.sample  = sample;
  assign push_item.restart = restart;
  assign push_item.last    = last;
  assign push_item.emit    = !warming;

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_count <= '0;
    end else if (push) begin
      warm_count <= warming ? warm_base + 1'b1 : warm_base;
    end
  end

endmodule
`default_nettype wire

### rtl/core/sdof_mul.sv
`default_nettype none
module sdof_mul import sdof_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  mul_req_t                req,
  output logic                    done,
  output logic signed [DataW-1:0] res
);

  logic [1:0]              phase;
  mul_kind_t               kind_r;
  logic signed [CoefW-1:0] a_r;
  logic signed [DataW-1:0] x_r;
  logic signed [56:0]      prod;
  logic signed [WideW-1:0] acc;
  logic signed [56:0]      a_ext;
  logic signed [56:0]      xh_ext;
  logic signed [56:0]      xl_ext;
  logic signed [WideW-1:0] rnd;
  logic signed [WideW-1:0] full;
  logic signed [WideW-1:0] shifted;

  assign a_ext  = 57'(a_r);
  assign xh_ext = 57'($signed(x_r[DataW-1:24]));
  assign xl_ext = $signed({33'b0, x_r[23:0]});

  // combine partial products, round if asked, scale down
  assign rnd  = (kind_r == MK_RND24) ? (80'sd1 <<< 23) : '0;
  assign full = acc + 80'(prod) + rnd;

  always_comb begin
    case (kind_r)
      MK_SH8:  shifted = full >>> 8;
      MK_SH16: shifted = full >>> 16;
      default: shifted = full >>> 24;
    endcase
  end

  // high half, then low half, then sum
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        2'd0: begin
          if (req.start) begin
            a_r    <= req.a;
            x_r    <= req.x;
            kind_r <= req.kind;
            phase  <= 2'd1;
          end
        end
        2'd1: begin
          prod  <= a_ext * xh_ext;
          phase <= 2'd2;
        end
        2'd2: begin
          acc   <= 80'(prod) <<< 24;
          prod  <= a_ext * xl_ext;
          phase <= 2'd3;
        end
        default: begin
          res   <= sat48(shifted);
          done  <= 1'b1;
          phase <= 2'd0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/core/sdof_div.sv
`default_nettype none
module sdof_div import sdof_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DivW-1:0]  num,
  input  wire logic [StepW-1:0] den,
  output logic                  done,
  output logic [DivW-1:0]       quo
);

  logic               busy;
  logic [DivCntW-1:0] cnt;
  logic [StepW-1:0]   rem;
  logic [StepW-1:0]   den_r;
  logic [StepW:0]     trial;
  logic               fits;

  assign trial = {rem, quo[DivW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= num;
        den_r <= den;
        rem   <= '0;
        cnt   <= DivCntW'(DivW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= fits ? StepW'(trial - {1'b0, den_r}) : trial[StepW-1:0];
        quo <= {quo[DivW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/sdof_back.sv
`default_nettype none
module sdof_back import sdof_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  cfg_t              cfg,
  input  wire logic         q_empty,
  input  item_t             q_item,
  output logic              pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [31:0]       response,
  output logic              packet_end
);

  back_state_t state, state_next;
  op_t         op;

  logic [StepW-1:0] n_r;
  logic [StepW-1:0] cnt;
  logic [1:0]       sel_r;
  logic signed [SampleW-1:0] sample_r;
  logic             last_r;
  logic             emit_r;
  logic             neg_r;

  logic signed [DataW-1:0] mean, prev, xd, xv, osc_acc;
  logic signed [DataW-1:0] xs, dtmp, d_r, slope, disp_new, vel_new, peak;
  logic signed [UaccW-1:0] u_acc;
  logic signed [SumW-1:0]  sum;
  logic signed [DataW-1:0] u;

  mul_req_t                mreq;
  logic                    mdone;
  logic signed [DataW-1:0] mres;
  logic signed [SumW-1:0]  sres;

  logic                    div_start;
  logic                    div_done;
  logic [DivW-1:0]         div_quo;
  logic signed [DivW-1:0]  diff;
  logic [DivW-1:0]         diff_mag;
  logic signed [WideW-1:0] quo_signed;

  logic [StepW-1:0]        n_eff;
  logic [1:0]              sel_eff;
  logic signed [DataW-1:0] v_sel;
  logic [DataW:0]          v_mag;
  logic [DataW:0]          peak_mag;
  logic                    out_load;
  logic signed [WideW-1:0] resp_wide;

  // sub-step count of zero runs one step; select three means acceleration
  assign n_eff   = (cfg.mode[7:0] == '0) ? StepW'(1) : cfg.mode[7:0];
  assign sel_eff = (cfg.mode[9:8] > SEL_ACC) ? SEL_ACC : cfg.mode[9:8];

  assign u    = sat48(80'(u_acc));
  assign sres = SumW'(mres);

  // operand select for the shared multiplier
  always_comb begin
    mreq.start = (state == B_MUL_ISSUE);
    mreq.kind  = MK_SH24;
    mreq.a     = '0;
    mreq.x     = '0;
    case (op)
      OP_GAIN: begin
        mreq.kind = MK_SH8;
        mreq.a    = cfg.gain;
        mreq.x    = DataW'(sample_r);
      end
      OP_MEAN: begin
        mreq.kind = MK_RND24;
        mreq.a    = MeanWeight;
        mreq.x    = dtmp;
      end
      OP_A0: begin mreq.a = $signed(cfg.a01[63:32]); mreq.x = xd;    end
      OP_A1: begin mreq.a = $signed(cfg.a01[31:0]);  mreq.x = xv;    end
      OP_B0: begin mreq.a = $signed(cfg.b01[63:32]); mreq.x = u;     end
      OP_B1: begin mreq.a = $signed(cfg.b01[31:0]);  mreq.x = slope; end
      OP_A2: begin mreq.a = $signed(cfg.a23[63:32]); mreq.x = xd;    end
      OP_A3: begin mreq.a = $signed(cfg.a23[31:0]);  mreq.x = xv;    end
      OP_B2: begin mreq.a = $signed(cfg.b23[63:32]); mreq.x = u;     end
      OP_B3: begin mreq.a = $signed(cfg.b23[31:0]);  mreq.x = slope; end
      OP_C: begin
        mreq.kind = MK_SH16;
        mreq.a    = $signed(cfg.osc[63:32]);
        mreq.x    = vel_new;
      end
      OP_W2: begin
        mreq.kind = MK_SH16;
        mreq.a    = $signed(cfg.osc[31:0]);
        mreq.x    = disp_new;
      end
      default: ;
    endcase
  end

  sdof_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mdone),
    .res  (mres)
  );

  // slope from the de-meaned step across the sub-steps
  assign diff     = DivW'(d_r) - DivW'(prev);
  assign diff_mag = diff[DivW-1] ? DivW'(-diff) : DivW'(diff);
  assign quo_signed = neg_r ? -$signed(80'(div_quo)) : $signed(80'(div_quo));

  sdof_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (diff_mag),
    .den   (n_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // peak tracking on the selected response
  always_comb begin
    case (sel_r)
      SEL_DISP: v_sel = disp_new;
      SEL_VEL:  v_sel = vel_new;
      default:  v_sel = osc_acc;
    endcase
  end
  assign v_mag     = v_sel[DataW-1] ? (DataW+1)'(-(DataW+1)'(v_sel)) : (DataW+1)'(v_sel);
  assign peak_mag  = peak[DataW-1] ? (DataW+1)'(-(DataW+1)'(peak)) : (DataW+1)'(peak);
  assign resp_wide = 80'(peak) >>> 8;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:      if (!q_empty) state_next = B_MUL_ISSUE;
      B_MUL_ISSUE: state_next = B_MUL_WAIT;
      B_MUL_WAIT: begin
        if (mdone) begin
          case (op)
            OP_MEAN: state_next = B_DEMEAN;
            OP_W2:   state_next = B_STEP_END;
            default: state_next = B_MUL_ISSUE;
          endcase
        end
      end
      B_DEMEAN:    state_next = emit_r ? B_DIV_ISSUE : B_IDLE;
      B_DIV_ISSUE: state_next = B_DIV_WAIT;
      B_DIV_WAIT:  if (div_done) state_next = B_MUL_ISSUE;
      B_STEP_END:  state_next = (cnt == n_r - 1'b1) ? B_FINISH : B_MUL_ISSUE;
      B_FINISH:    if (out_load) state_next = B_IDLE;
      default:     state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = (state == B_IDLE) && !q_empty;
    div_start = (state == B_DIV_ISSUE);
    out_load  = (state == B_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mean    <= '0;
      prev    <= '0;
      xd      <= '0;
      xv      <= '0;
      osc_acc <= '0;
      op      <= OP_GAIN;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            sample_r <= q_item.sample;
            last_r   <= q_item.last;
            emit_r   <= q_item.emit;
            n_r      <= n_eff;
            sel_r    <= sel_eff;
            op       <= OP_GAIN;
            if (q_item.restart) begin
              mean    <= '0;
              prev    <= '0;
              xd      <= '0;
              xv      <= '0;
              osc_acc <= '0;
            end
          end
        end
        B_MUL_WAIT: begin
          if (mdone) begin
            case (op)
              OP_GAIN: begin
                xs   <= mres;
                dtmp <= sat48(80'(mres) - 80'(mean));
                op   <= OP_MEAN;
              end
              OP_MEAN: mean <= sat48(80'(mean) + 80'(mres));
              OP_A0: begin sum <= sres;       op <= OP_A1; end
              OP_A1: begin sum <= sum + sres; op <= OP_B0; end
              OP_B0: begin sum <= sum - sres; op <= OP_B1; end
              OP_B1: begin
                disp_new <= sat48(80'(sum) - 80'(sres));
                op       <= OP_A2;
              end
              OP_A2: begin sum <= sres;       op <= OP_A3; end
              OP_A3: begin sum <= sum + sres; op <= OP_B2; end
              OP_B2: begin sum <= sum - sres; op <= OP_B3; end
              OP_B3: begin
                vel_new <= sat48(80'(sum) - 80'(sres));
                op      <= OP_C;
              end
              OP_C: begin sum <= sres; op <= OP_W2; end
              default: osc_acc <= sat48(-(80'(sum) + 80'(sres)));
            endcase
          end
        end
        B_DEMEAN: d_r <= sat48(80'(xs) - 80'(mean));
        B_DIV_ISSUE: neg_r <= diff[DivW-1];
        B_DIV_WAIT: begin
          if (div_done) begin
            slope <= sat48(quo_signed);
            u_acc <= UaccW'(prev);
            cnt   <= '0;
            peak  <= '0;
            op    <= OP_A0;
          end
        end
        B_STEP_END: begin
          xd    <= disp_new;
          xv    <= vel_new;
          if (v_mag > peak_mag) peak <= v_sel;
          u_acc <= u_acc + UaccW'(slope);
          cnt   <= cnt + 1'b1;
          op    <= OP_A0;
        end
        B_FINISH: begin
          if (out_load) prev <= d_r;
        end
        default: ;
      endcase
    end
  end

  // output register; holds a finished beat while the next item runs
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      packet_end <= last_r;
      if (resp_wide > 80'sd2147483647)       response <= 32'h7FFF_FFFF;
      else if (resp_wide < -80'sd2147483648) response <= 32'h8000_0000;
      else                                   response <= resp_wide[31:0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/sdof_response_spectrum_oscillator.sv
// A warm-up sample runs only the gain and mean products and then returns the back end to idle;
//   an emitting sample also runs the slope divide and n sub-steps, n = sub-steps (1..255).
// One sample at a time: the shared 32x25 multiplier (ten products per sub-step) and the
//   slope divide set the time.
// A four-entry queue takes input while the back end works; a finished result waits in the
//   output register. Reset (rst, synchronous) clears state and loads register defaults.
`default_nettype none
module sdof_response_spectrum_oscillator import sdof_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  input  wire logic [0:0]  s_tuser,   // [0] restart
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] response
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t pop_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain   <= 32'sd65536;
      cfg.mode   <= 10'd513;
      cfg.warmup <= '0;
      cfg.a01    <= '0;
      cfg.a23    <= '0;
      cfg.b01    <= '0;
      cfg.b23    <= '0;
      cfg.osc    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:   cfg.gain   <= $signed(cfg_data[31:0]);
        CFG_MODE:   cfg.mode   <= cfg_data[9:0];
        CFG_WARMUP: cfg.warmup <= cfg_data[WarmW-1:0];
        CFG_A01:    cfg.a01    <= cfg_data;
        CFG_A23:    cfg.a23    <= cfg_data;
        CFG_B01:    cfg.b01    <= cfg_data;
        CFG_B23:    cfg.b23    <= cfg_data;
        CFG_OSC:    cfg.osc    <= cfg_data;
        default: ;
      endcase
    end
  end

  sdof_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .sample    ($signed(s_tdata)),
    .restart   (s_tuser[0]),
    .last      (s_tlast),
    .warmup    (cfg.warmup),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  sdof_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  sdof_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .response   (m_tdata),
    .packet_end (m_tlast)
  );

endmodule
`default_nettype wire
